// ----- rtl/bcm_pkg.sv -----
// Shared types and constants for the battery cutoff monitor.
// Used by every module of the block; depends on nothing.

package bcm_pkg;

    localparam int MV_W     = 16;
    localparam int RUN_W    = 8;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        LEVEL_NORMAL  = 2'd0,
        LEVEL_LOW     = 2'd1,
        LEVEL_CUTOFF  = 2'd2,
        LEVEL_UNKNOWN = 2'd3
    } level_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF_MV   = 2'd0,
        CFG_LOW_WARN_MV = 2'd1,
        CFG_FLOOR_MV    = 2'd2,
        CFG_CONSEC      = 2'd3
    } cfg_index_t;

    localparam logic [MV_W-1:0]  CUTOFF_MV_RESET   = 16'd3300;
    localparam logic [MV_W-1:0]  LOW_WARN_MV_RESET = 16'd3500;
    localparam logic [MV_W-1:0]  FLOOR_MV_RESET    = 16'd500;
    localparam logic [RUN_W-1:0] CONSEC_RESET      = 8'd3;

    // Classified request handed from front to back.
    typedef struct packed {
        logic is_warning;
        logic implausible;
        logic ext_supply;
        logic below_cutoff;
        logic below_warn;
    } bcm_item_t;

endpackage

// ----- rtl/bcm_front.sv -----
// Front part: compares each incoming request against the thresholds.
// Depends on bcm_pkg.

module bcm_front
    import bcm_pkg::*;
(
    input  logic            kind,
    input  logic [MV_W-1:0] millivolts,
    input  logic            ext_supply,
    input  logic [MV_W-1:0] cutoff_mv,
    input  logic [MV_W-1:0] low_warn_mv,
    input  logic [MV_W-1:0] floor_mv,
    output bcm_item_t       item
);

    always_comb
    begin
        item.is_warning   = kind;
        item.implausible  = (millivolts <= floor_mv);
        item.ext_supply   = ext_supply;
        item.below_cutoff = (millivolts < cutoff_mv);
        item.below_warn   = (millivolts < low_warn_mv);
    end

endmodule

// ----- rtl/bcm_queue.sv -----
// Short queue between front and back; holds classified requests.
// Depends on bcm_pkg.

module bcm_queue
    import bcm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  bcm_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output bcm_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(DEPTH - 1);

    bcm_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == DEPTH_C);
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/bcm_back.sv -----
// Back part: applies classified requests to the level state and counters
// and holds the result register. Depends on bcm_pkg.

module bcm_back
    import bcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [RUN_W-1:0]   consecutive_needed,
    input  logic               item_valid,
    input  bcm_item_t          item,
    output logic               item_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output level_t             level,
    output logic               settings_write_ok,
    output logic [COUNT_W-1:0] implausible_count,
    output logic [COUNT_W-1:0] warning_count
);

    level_t             level_reg, level_next;
    logic [RUN_W-1:0]   run_cut_reg, run_cut_next;
    logic [RUN_W-1:0]   run_warn_reg, run_warn_next;
    logic [COUNT_W-1:0] rejected_reg, rejected_next;
    logic [COUNT_W-1:0] warnings_reg, warnings_next;
    logic               warned_reg, warned_next;
    logic               out_valid_reg, out_valid_next;
    level_t             out_level_reg;
    logic               out_ok_reg;
    logic               ok_next;

    assign item_pop          = item_valid && (!out_valid_reg || !out_stall);
    assign out_valid         = out_valid_reg;
    assign level             = out_level_reg;
    assign settings_write_ok = out_ok_reg;
    assign implausible_count = rejected_reg;
    assign warning_count     = warnings_reg;

    always_comb
    begin
        level_next    = level_reg;
        run_cut_next  = run_cut_reg;
        run_warn_next = run_warn_reg;
        rejected_next = rejected_reg;
        warnings_next = warnings_reg;
        warned_next   = warned_reg;
        if (item.is_warning)
        begin
            warnings_next = (warnings_reg == '1) ? warnings_reg : warnings_reg + 1'b1;
            warned_next   = 1'b1;
        end
        else if (level_reg == LEVEL_CUTOFF)
        begin
            level_next = LEVEL_CUTOFF;
        end
        else if (item.implausible)
        begin
            rejected_next = (rejected_reg == '1) ? rejected_reg : rejected_reg + 1'b1;
            run_cut_next  = '0;
            run_warn_next = '0;
        end
        else if (item.ext_supply)
        begin
            run_cut_next  = '0;
            run_warn_next = '0;
            level_next    = LEVEL_NORMAL;
        end
        else
        begin
            if (item.below_cutoff)
            begin
                run_cut_next = (run_cut_reg == '1) ? run_cut_reg : run_cut_reg + 1'b1;
            end
            else
            begin
                run_cut_next = '0;
            end
            if (item.below_warn)
            begin
                run_warn_next = (run_warn_reg == '1) ? run_warn_reg : run_warn_reg + 1'b1;
            end
            else
            begin
                run_warn_next = '0;
            end
            priority if (run_cut_next >= consecutive_needed)
            begin
                level_next = LEVEL_CUTOFF;
            end
            else if (run_warn_next >= consecutive_needed)
            begin
                level_next = LEVEL_LOW;
            end
            else if (run_warn_next == '0)
            begin
                level_next = LEVEL_NORMAL;
            end
            else
            begin
                level_next = level_reg;
            end
        end
        ok_next = !warned_next && (level_next != LEVEL_LOW) && (level_next != LEVEL_CUTOFF);

        if (item_pop)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= LEVEL_UNKNOWN;
            run_cut_reg   <= '0;
            run_warn_reg  <= '0;
            rejected_reg  <= '0;
            warnings_reg  <= '0;
            warned_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_level_reg <= LEVEL_UNKNOWN;
            out_ok_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_pop)
            begin
                level_reg     <= level_next;
                run_cut_reg   <= run_cut_next;
                run_warn_reg  <= run_warn_next;
                rejected_reg  <= rejected_next;
                warnings_reg  <= warnings_next;
                warned_reg    <= warned_next;
                out_level_reg <= level_next;
                out_ok_reg    <= ok_next;
            end
        end
    end

endmodule

// ----- rtl/battery_cutoff_monitor.sv -----
// Top level of the battery cutoff monitor: configuration registers, front
// classifier, request queue and back state unit. Depends on bcm_pkg.
//
// Takes one request (battery sample or supply warning) per clock while not
// stalled and returns one result per request, in order. A request is
// classified against the thresholds on entry to the queue, and the back unit
// updates the run counters, level and event counters in the cycle it pops the
// request. The back unit's single state update per cycle sets the sustained
// rate of one request per clock while out_stall is low. Cutoff, once reached,
// holds until reset. The queue lets input keep flowing while a result waits
// to be taken. Write configuration only while idle.

module battery_cutoff_monitor
    import bcm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MV_W-1:0]      cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [MV_W-1:0]      millivolts,
    input  logic                 ext_supply,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           level,
    output logic                 settings_write_ok,
    output logic [COUNT_W-1:0]   implausible_count,
    output logic [COUNT_W-1:0]   warning_count
);

    logic [MV_W-1:0]  cutoff_reg;
    logic [MV_W-1:0]  low_warn_reg;
    logic [MV_W-1:0]  floor_reg;
    logic [RUN_W-1:0] consec_reg;

    bcm_item_t front_item;
    bcm_item_t queue_item;
    logic      queue_full;
    logic      queue_not_empty;
    logic      queue_pop;
    logic      queue_push;
    level_t    back_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg   <= CUTOFF_MV_RESET;
            low_warn_reg <= LOW_WARN_MV_RESET;
            floor_reg    <= FLOOR_MV_RESET;
            consec_reg   <= CONSEC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CUTOFF_MV:   cutoff_reg   <= cfg_data;
                CFG_LOW_WARN_MV: low_warn_reg <= cfg_data;
                CFG_FLOOR_MV:    floor_reg    <= cfg_data;
                CFG_CONSEC:      consec_reg   <= cfg_data[RUN_W-1:0];
                default:         consec_reg   <= consec_reg;
            endcase
        end
    end

    assign in_stall   = queue_full;
    assign queue_push = in_valid && !queue_full;
    assign level      = back_level;

    bcm_front u_front (
        .kind        (kind),
        .millivolts  (millivolts),
        .ext_supply  (ext_supply),
        .cutoff_mv   (cutoff_reg),
        .low_warn_mv (low_warn_reg),
        .floor_mv    (floor_reg),
        .item        (front_item)
    );

    bcm_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_item  (queue_item)
    );

    bcm_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .consecutive_needed (consec_reg),
        .item_valid         (queue_not_empty),
        .item               (queue_item),
        .item_pop           (queue_pop),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .level              (back_level),
        .settings_write_ok  (settings_write_ok),
        .implausible_count  (implausible_count),
        .warning_count      (warning_count)
    );

endmodule
